// File: rtl/dcb_pkg.sv
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared widths, constants, types and constant functions of the double-sided
// Crystal Ball evaluator.
// ----------------------------------------------------------------------------
package dcb_pkg;

  // Default number of fraction bits of the Q formats
  localparam int FRAC_BITS_DEF = 16;

  // Field and register widths
  localparam int X_W        = 32;
  localparam int MU_W       = 32;
  localparam int SIG_W      = 31;
  localparam int ALPHA_W    = 20;
  localparam int POWER_W    = 24;
  localparam int OUT_W      = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Log domain: exponents are Q30
  localparam int LG_FRAC   = 30;
  localparam int MANT_W    = 32;
  localparam int SQ30_W    = 38;
  localparam int EXP_INT_W = 5;
  localparam int ACC_W     = 33;

  // round(2^24 * log2(e) / 2)
  localparam int                LOG2E_W    = 24;
  localparam logic [LOG2E_W-1:0] HALF_LOG2E = 24'd12102203;

  // Configuration register indices
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MEAN       = 3'd0,
    CFG_SIGMA      = 3'd1,
    CFG_LOW_ALPHA  = 3'd2,
    CFG_LOW_POWER  = 3'd3,
    CFG_HIGH_ALPHA = 3'd4,
    CFG_HIGH_POWER = 3'd5
  } cfg_reg_e;

  // Per-item control going into the exponent pipe
  typedef struct packed {
    logic tail;  // power-law tail rather than Gaussian core
    logic zero;  // result forced to zero
  } ctrl_t;

  // Exponent handed to the 2^-E unit
  typedef struct packed {
    logic                 zero;
    logic [EXP_INT_W-1:0] e_int;
    logic [LG_FRAC-1:0]   e_frac;
  } expo_t;

  // Floor square root of a 64-bit value
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Q32 factor 2^(-2^-k), k >= 1, by repeated floor square roots
  function automatic logic [31:0] pow2_factor(input int k);
    logic [63:0] f;
    f = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 1; i < LG_FRAC; i++) begin
      if (i < k) begin
        f = isqrt64(f << 32);
      end
    end
    return f[31:0];
  endfunction

endpackage

// File: rtl/double_crystal_ball_eval.sv
// ----------------------------------------------------------------------------
// double_crystal_ball_eval
// Unnormalised double-sided Crystal Ball function of a Q16.16 sample,
// returned as unsigned Q1.31 (2^31 = 1.0).
// ----------------------------------------------------------------------------
// A fully pipelined evaluator: it takes one sample per clock and returns one
// result per sample, in order. Most of its depth lies in the bit-per-stage
// divider that forms u = (x-mu)/sigma and the tail ratio n/alpha
// (32 + FRAC_BITS stages), the two 31-stage logarithm pipes and the 31-stage
// 2^-E unit. The whole pipe advances together; it holds while a finished
// result is stalled at the output. Configuration registers may be written
// only while no item is in flight; a register written as zero is used as
// one LSB.
// ----------------------------------------------------------------------------
module double_crystal_ball_eval #(
  parameter int FRAC_BITS = dcb_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dcb_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [dcb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [dcb_pkg::X_W-1:0] sample_x_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dcb_pkg::OUT_W-1:0]      density_value_o
);

  localparam int DW    = dcb_pkg::X_W + FRAC_BITS;
  localparam int IN_W  = DW + 1;
  localparam int SQV_W = FRAC_BITS + 4;
  localparam int XW    = dcb_pkg::X_W;
  localparam int SW    = dcb_pkg::SIG_W;
  localparam int AW    = dcb_pkg::ALPHA_W;
  localparam int NW    = dcb_pkg::POWER_W;
  localparam logic [DW-1:0] FAR_LIM = {{(DW-1){1'b0}}, 1'b1} << (FRAC_BITS + 4);

  // Configuration registers
  logic [dcb_pkg::MU_W-1:0] mean_q;
  logic [SW-1:0] sigma_q;
  logic [AW-1:0] low_alpha_q, high_alpha_q;
  logic [NW-1:0] low_power_q, high_power_q;

  logic [SW-1:0] sigma_eff;
  logic [AW-1:0] low_alpha_eff, high_alpha_eff;
  logic [NW-1:0] low_power_eff, high_power_eff;

  logic en;

  logic [XW:0]   d_d;
  logic          neg_d;
  logic [XW-1:0] mag_d;
  logic          vb_q, neg_b_q;
  logic [XW-1:0] mag_b_q;

  logic          div_valid, div_neg;
  logic [DW-1:0] um, ratio;

  logic          low_tail, core;
  logic [AW-1:0] a_sel;
  logic [NW-1:0] n_sel;
  logic [DW-1:0] a_ext, excess, r1, sq_src;
  dcb_pkg::ctrl_t ctrl_d;
  logic [IN_W-1:0] t_d;

  logic            vc_q;
  dcb_pkg::ctrl_t  ctrl_c_q;
  logic [IN_W-1:0] t_c_q, r_c_q;
  logic [SQV_W-1:0] sqv_c_q;
  logic [NW-1:0]   n_c_q;

  logic           ex_valid;
  dcb_pkg::expo_t expo;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q       <= '0;
      sigma_q      <= SW'(65536);
      low_alpha_q  <= AW'(131072);
      low_power_q  <= NW'(131072);
      high_alpha_q <= AW'(131072);
      high_power_q <= NW'(131072);
    end else if (cfg_we_i) begin
      unique case (dcb_pkg::cfg_reg_e'(cfg_addr_i))
        dcb_pkg::CFG_MEAN:       mean_q       <= cfg_data_i;
        dcb_pkg::CFG_SIGMA:      sigma_q      <= cfg_data_i[SW-1:0];
        dcb_pkg::CFG_LOW_ALPHA:  low_alpha_q  <= cfg_data_i[AW-1:0];
        dcb_pkg::CFG_LOW_POWER:  low_power_q  <= cfg_data_i[NW-1:0];
        dcb_pkg::CFG_HIGH_ALPHA: high_alpha_q <= cfg_data_i[AW-1:0];
        dcb_pkg::CFG_HIGH_POWER: high_power_q <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  // Zero registers count as one LSB
  assign sigma_eff      = (sigma_q == '0)      ? SW'(1) : sigma_q;
  assign low_alpha_eff  = (low_alpha_q == '0)  ? AW'(1) : low_alpha_q;
  assign high_alpha_eff = (high_alpha_q == '0) ? AW'(1) : high_alpha_q;
  assign low_power_eff  = (low_power_q == '0)  ? NW'(1) : low_power_q;
  assign high_power_eff = (high_power_q == '0) ? NW'(1) : high_power_q;

  // Whole pipe moves unless the output item is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Entry stage: signed distance from the mean
  assign d_d   = {sample_x_i[XW-1], sample_x_i} - {mean_q[XW-1], mean_q};
  assign neg_d = d_d[XW];
  assign mag_d = neg_d ? XW'(-d_d) : d_d[XW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_b_q <= neg_d;
      mag_b_q <= mag_d;
    end
  end

  // u and n/alpha
  dcb_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (vb_q),
    .neg_i        (neg_b_q),
    .mag_i        (mag_b_q),
    .sigma_i      (sigma_eff),
    .low_alpha_i  (low_alpha_eff),
    .low_power_i  (low_power_eff),
    .high_alpha_i (high_alpha_eff),
    .high_power_i (high_power_eff),
    .valid_o      (div_valid),
    .neg_o        (div_neg),
    .quot_o       (um),
    .ratio_o      (ratio)
  );

  // Region select: low tail, core or high tail
  assign a_sel    = div_neg ? low_alpha_eff : high_alpha_eff;
  assign n_sel    = div_neg ? low_power_eff : high_power_eff;
  assign a_ext    = DW'(a_sel);
  assign low_tail = div_neg && (um > DW'(low_alpha_eff));
  assign core     = !low_tail && (div_neg || (um < DW'(high_alpha_eff)));
  assign excess   = um - a_ext;
  assign r1       = (ratio == '0) ? DW'(1) : ratio;
  assign t_d      = IN_W'(r1) + IN_W'(excess);
  assign sq_src   = core ? um : a_ext;

  assign ctrl_d.tail = !core;
  assign ctrl_d.zero = core ? (um >= FAR_LIM) : (a_ext >= FAR_LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctrl_c_q <= ctrl_d;
      t_c_q    <= t_d;
      r_c_q    <= IN_W'(r1);
      sqv_c_q  <= sq_src[SQV_W-1:0];
      n_c_q    <= n_sel;
    end
  end

  // Exponent in the log2 domain
  dcb_exponent #(.FRAC_BITS(FRAC_BITS), .IN_W(IN_W)) u_expo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .ctrl_i  (ctrl_c_q),
    .t_i     (t_c_q),
    .r_i     (r_c_q),
    .sqv_i   (sqv_c_q),
    .n_i     (n_c_q),
    .valid_o (ex_valid),
    .expo_o  (expo)
  );

  // 2^-E and output register
  dcb_exp2 u_exp2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (ex_valid),
    .expo_i    (expo),
    .valid_o   (out_valid_o),
    .density_o (density_value_o)
  );

endmodule

// File: rtl/dcb_divider.sv
// ----------------------------------------------------------------------------
// dcb_divider
// Pipelined restoring divider, one quotient bit per stage. Two lanes run side
// by side: the normalised distance |x-mu|/sigma and the tail ratio n/alpha.
// ----------------------------------------------------------------------------
module dcb_divider #(
  parameter  int FRAC_BITS = dcb_pkg::FRAC_BITS_DEF,
  localparam int DW        = dcb_pkg::X_W + FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         neg_i,
  input  logic [dcb_pkg::X_W-1:0]      mag_i,
  input  logic [dcb_pkg::SIG_W-1:0]    sigma_i,
  input  logic [dcb_pkg::ALPHA_W-1:0]  low_alpha_i,
  input  logic [dcb_pkg::POWER_W-1:0]  low_power_i,
  input  logic [dcb_pkg::ALPHA_W-1:0]  high_alpha_i,
  input  logic [dcb_pkg::POWER_W-1:0]  high_power_i,
  output logic                         valid_o,
  output logic                         neg_o,
  output logic [DW-1:0]                quot_o,
  output logic [DW-1:0]                ratio_o
);

  localparam int SW = dcb_pkg::SIG_W;
  localparam int AW = dcb_pkg::ALPHA_W;
  localparam int PAD = DW - dcb_pkg::POWER_W - FRAC_BITS;

  logic          vld_q  [0:DW];
  logic          neg_q  [0:DW];
  logic [DW-1:0] qd1_q  [0:DW];
  logic [SW-1:0] rem1_q [0:DW];
  logic [DW-1:0] qd2_q  [0:DW];
  logic [AW-1:0] rem2_q [0:DW];

  logic [dcb_pkg::POWER_W-1:0] n_sel;

  // Stage zero: dividends enter, remainders start empty
  assign n_sel     = neg_i ? low_power_i : high_power_i;
  assign vld_q[0]  = valid_i;
  assign neg_q[0]  = neg_i;
  assign qd1_q[0]  = {mag_i, {FRAC_BITS{1'b0}}};
  assign rem1_q[0] = '0;
  assign qd2_q[0]  = {{PAD{1'b0}}, n_sel, {FRAC_BITS{1'b0}}};
  assign rem2_q[0] = '0;

  for (genvar j = 0; j < DW; j++) begin : g_stage
    logic [SW:0]   tr1;
    logic [SW:0]   df1;
    logic          ge1;
    logic [AW-1:0] a_sel;
    logic [AW:0]   tr2;
    logic [AW:0]   df2;
    logic          ge2;

    // Trial subtract of the distance lane
    assign tr1 = {rem1_q[j], qd1_q[j][DW-1]};
    assign df1 = tr1 - {1'b0, sigma_i};
    assign ge1 = (tr1 >= {1'b0, sigma_i});

    // Trial subtract of the ratio lane, divisor follows the item's side
    assign a_sel = neg_q[j] ? low_alpha_i : high_alpha_i;
    assign tr2   = {rem2_q[j], qd2_q[j][DW-1]};
    assign df2   = tr2 - {1'b0, a_sel};
    assign ge2   = (tr2 >= {1'b0, a_sel});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[j+1]  <= neg_q[j];
        rem1_q[j+1] <= ge1 ? df1[SW-1:0] : tr1[SW-1:0];
        qd1_q[j+1]  <= {qd1_q[j][DW-2:0], ge1};
        rem2_q[j+1] <= ge2 ? df2[AW-1:0] : tr2[AW-1:0];
        qd2_q[j+1]  <= {qd2_q[j][DW-2:0], ge2};
      end
    end
  end

  assign valid_o = vld_q[DW];
  assign neg_o   = neg_q[DW];
  assign quot_o  = qd1_q[DW];
  assign ratio_o = qd2_q[DW];

endmodule

// File: rtl/dcb_log2.sv
// ----------------------------------------------------------------------------
// dcb_log2
// Pipelined base-2 logarithm of an unsigned integer >= 1, result Q30. One
// normalising stage, then one mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
module dcb_log2 #(
  parameter  int IN_W = dcb_pkg::X_W + dcb_pkg::FRAC_BITS_DEF + 1,
  localparam int KW   = $clog2(IN_W),
  localparam int LGW  = KW + dcb_pkg::LG_FRAC
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IN_W-1:0] val_i,
  output logic [LGW-1:0]  lg_o
);

  localparam int LF = dcb_pkg::LG_FRAC;
  localparam int MW = dcb_pkg::MANT_W;

  logic [KW-1:0]      k_c;
  logic [IN_W+MW-2:0] ext;
  logic [MW-1:0]      m_c;

  logic [MW-1:0] m_q [0:LF];
  logic [KW-1:0] k_q [0:LF];
  logic [LF-1:0] f_q [0:LF];

  // Leading one search
  always_comb begin
    k_c = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (val_i[i]) begin
        k_c = KW'(i);
      end
    end
  end

  // Bring the leading one to bit 31 (truncating)
  assign ext = {val_i, {(MW-1){1'b0}}} >> k_c;
  assign m_c = ext[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m_c;
      k_q[0] <= k_c;
      f_q[0] <= '0;
    end
  end

  // One fraction bit per stage: square, test for >= 2.0, renormalise
  for (genvar i = 1; i <= LF; i++) begin : g_iter
    logic [2*MW-1:0] sq;
    logic [MW:0]     m2;

    assign sq = m_q[i-1] * m_q[i-1];
    assign m2 = sq[2*MW-1:MW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i] <= m2[MW] ? m2[MW:1] : m2[MW-1:0];
        f_q[i] <= {f_q[i-1][LF-2:0], m2[MW]};
        k_q[i] <= k_q[i-1];
      end
    end
  end

  assign lg_o = {k_q[LF], f_q[LF]};

endmodule

// File: rtl/dcb_exponent.sv
// ----------------------------------------------------------------------------
// dcb_exponent
// Builds the Q30 exponent E of 2^-E: the Gaussian term u^2*log2(e)/2 and,
// for tails, n*(lg(t)-lg(r)) on top of the alpha term.
// ----------------------------------------------------------------------------
module dcb_exponent #(
  parameter  int FRAC_BITS = dcb_pkg::FRAC_BITS_DEF,
  parameter  int IN_W      = dcb_pkg::X_W + dcb_pkg::FRAC_BITS_DEF + 1,
  localparam int SQV_W     = FRAC_BITS + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  dcb_pkg::ctrl_t              ctrl_i,
  input  logic [IN_W-1:0]             t_i,
  input  logic [IN_W-1:0]             r_i,
  input  logic [SQV_W-1:0]            sqv_i,
  input  logic [dcb_pkg::POWER_W-1:0] n_i,
  output logic                        valid_o,
  output dcb_pkg::expo_t              expo_o
);

  localparam int LF       = dcb_pkg::LG_FRAC;
  localparam int KW       = $clog2(IN_W);
  localparam int LGW      = KW + LF;
  localparam int LG_DEPTH = LF + 1;
  localparam int SH       = 2 * FRAC_BITS - LF;
  localparam int SHR      = (SH > 0) ? SH : 0;
  localparam int SHL      = (SH < 0) ? -SH : 0;
  localparam int SQP_W    = 2 * SQV_W + SHL;
  localparam int Q30W     = dcb_pkg::SQ30_W;
  localparam int CW       = dcb_pkg::LOG2E_W;
  localparam int NW       = dcb_pkg::POWER_W;
  localparam int PW       = NW + LGW;
  localparam int PSH_W    = PW - FRAC_BITS;
  localparam int EW       = ((PSH_W > Q30W) ? PSH_W : Q30W) + 1;
  localparam int IW       = dcb_pkg::EXP_INT_W;

  logic [LGW-1:0] lg_t;
  logic [LGW-1:0] lg_r;

  logic           vld_q  [0:LG_DEPTH];
  dcb_pkg::ctrl_t ctrl_q [0:LG_DEPTH];
  logic [NW-1:0]  n_q    [0:LG_DEPTH];
  logic [Q30W-1:0] g_q   [2:LG_DEPTH];
  logic [2*SQV_W-1:0] sq_q;

  logic [SQP_W-1:0]   sqp;
  logic [Q30W-1:0]    sq30;
  logic [Q30W+CW-1:0] gp;

  logic           vld1_q, vld2_q, vld3_q;
  dcb_pkg::ctrl_t ctrl1_q, ctrl2_q;
  logic [NW-1:0]  n1_q;
  logic [Q30W-1:0] g1_q, g2_q;
  logic [LGW-1:0] diff_q;
  logic [PW-1:0]  prod_q;
  logic [EW-1:0]  e_d;
  dcb_pkg::expo_t expo_q;

  // Logarithms of t and r
  dcb_log2 #(.IN_W(IN_W)) u_lg_t (
    .clk_i (clk_i),
    .en_i  (en_i),
    .val_i (t_i),
    .lg_o  (lg_t)
  );

  dcb_log2 #(.IN_W(IN_W)) u_lg_r (
    .clk_i (clk_i),
    .en_i  (en_i),
    .val_i (r_i),
    .lg_o  (lg_r)
  );

  assign vld_q[0]  = valid_i;
  assign ctrl_q[0] = ctrl_i;
  assign n_q[0]    = n_i;

  // Control and tail power ride alongside the log pipes
  for (genvar i = 1; i <= LG_DEPTH; i++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctrl_q[i] <= ctrl_q[i-1];
        n_q[i]    <= n_q[i-1];
      end
    end
  end

  // Gaussian term: square, then scale by log2(e)/2
  assign sqp  = SQP_W'(sq_q) << SHL;
  assign sq30 = Q30W'(sqp >> SHR);
  assign gp   = sq30 * dcb_pkg::HALF_LOG2E;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sqv_i * sqv_i;
      g_q[2] <= gp[Q30W+CW-1:CW];
    end
  end

  for (genvar i = 3; i <= LG_DEPTH; i++) begin : g_gdly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        g_q[i] <= g_q[i-1];
      end
    end
  end

  // Log difference, clipped at zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= (lg_t > lg_r) ? (lg_t - lg_r) : '0;
      ctrl1_q <= ctrl_q[LG_DEPTH];
      n1_q    <= n_q[LG_DEPTH];
      g1_q    <= g_q[LG_DEPTH];
    end
  end

  // Power times log difference
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= n1_q * diff_q;
      ctrl2_q <= ctrl1_q;
      g2_q    <= g1_q;
    end
  end

  // Sum, split into integer and fraction, flag underflow
  assign e_d = (ctrl2_q.tail ? EW'(prod_q[PW-1:FRAC_BITS]) : EW'(0)) + EW'(g2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      expo_q.zero   <= ctrl2_q.zero | (|e_d[EW-1:LF+IW]);
      expo_q.e_int  <= e_d[LF+IW-1:LF];
      expo_q.e_frac <= e_d[LF-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_q[LG_DEPTH];
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  assign valid_o = vld3_q;
  assign expo_o  = expo_q;

endmodule

// File: rtl/dcb_exp2.sv
// ----------------------------------------------------------------------------
// dcb_exp2
// Pipelined 2^-E, E in Q30: one constant multiply per fraction bit, then the
// integer part shifts the Q32 accumulator down to the Q1.31 result.
// ----------------------------------------------------------------------------
module dcb_exp2 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  dcb_pkg::expo_t            expo_i,
  output logic                      valid_o,
  output logic [dcb_pkg::OUT_W-1:0] density_o
);

  localparam int LF = dcb_pkg::LG_FRAC;
  localparam int AW = dcb_pkg::ACC_W;
  localparam int OW = dcb_pkg::OUT_W;

  logic           vld_q [0:LF];
  dcb_pkg::expo_t ex_q  [0:LF];
  logic [AW-1:0]  acc_q [0:LF];

  logic [OW-1:0]  half;
  logic [OW-1:0]  dens_q;
  logic           vout_q;

  // Accumulator starts at 1.0 in Q32
  assign vld_q[0] = valid_i;
  assign ex_q[0]  = expo_i;
  assign acc_q[0] = {1'b1, {(AW-1){1'b0}}};

  for (genvar j = 1; j <= LF; j++) begin : g_mul
    localparam logic [31:0] FK = dcb_pkg::pow2_factor(j);
    logic [AW+31:0] prod;

    assign prod = acc_q[j-1] * FK;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ex_q[j]  <= ex_q[j-1];
        acc_q[j] <= ex_q[j-1].e_frac[LF-j] ? prod[AW+31:32] : acc_q[j-1];
      end
    end
  end

  // Final shift by 1 + integer part
  assign half = acc_q[LF][AW-1:1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dens_q <= ex_q[LF].zero ? '0 : (half >> ex_q[LF].e_int);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= vld_q[LF];
    end
  end

  assign valid_o   = vout_q;
  assign density_o = dens_q;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the double-sided Crystal Ball evaluator: samples are driven
// through several register settings, each result is compared in order with a
// bit-exact log2-domain model held by a small scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int                  FRAC      = 16;
  localparam logic [dcb_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 3'd6;
  localparam longint unsigned     FAR_Q     = 64'd16 << FRAC;
  localparam longint unsigned     HALF_L2E  = 64'd12102203;
  localparam int                  WD_LIMIT  = 5000;

  // Bit-exact density model with an ordered store of expected values
  class density_board;
    longint                 mu;
    longint unsigned        sig, a_lo, n_lo, a_hi, n_hi;
    longint unsigned        step_fac[30];
    logic [dcb_pkg::OUT_W-1:0] density_q[$];
    int                     errors;

    function new();
      longint unsigned f;
      mu = 0; sig = 65536; a_lo = 131072; n_lo = 131072; a_hi = 131072; n_hi = 131072;
      errors = 0;
      f = floor_sqrt(64'h8000_0000_0000_0000);
      for (int j = 0; j < 30; j++) begin
        step_fac[j] = f;
        f = floor_sqrt(f << 32);
      end
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned one_lsb(longint unsigned v);
      return (v == 0) ? 64'd1 : v;
    endfunction

    // log2 in Q30
    function longint unsigned log2_q30(longint unsigned v);
      int k;
      longint unsigned m, res;
      k = 63;
      while (k > 0 && v[k] == 1'b0) k--;
      m = (k > 31) ? (v >> (k - 31)) : (v << (31 - k));
      res = longint'(k) << 30;
      for (int b = 29; b >= 0; b--) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          res[b] = 1'b1;
          m = m >> 1;
        end
      end
      return res;
    endfunction

    // 2^-e, e in Q30, result Q1.31
    function longint unsigned exp2_neg(longint unsigned e);
      longint unsigned ip, acc;
      ip = e >> 30;
      acc = 64'd1 << 32;
      if (ip >= 32) return 0;
      for (int j = 0; j < 30; j++)
        if (e[29-j]) acc = (acc * step_fac[j]) >> 32;
      return acc >> (1 + ip);
    endfunction

    function longint unsigned tail_density(longint unsigned a, longint unsigned n,
                                           longint unsigned excess);
      longint unsigned r, t, lr, lt, diff, e;
      if (a >= FAR_Q) return 0;
      r = one_lsb((n << FRAC) / a);
      t = r + excess;
      lr = log2_q30(r);
      lt = log2_q30(t);
      diff = (lt > lr) ? lt - lr : 0;
      e = ((n * diff) >> FRAC) + ((((a * a) >> 2) * HALF_L2E) >> 24);
      return exp2_neg(e);
    endfunction

    function void write_reg(logic [dcb_pkg::CFG_ADDR_W-1:0] idx,
                            logic [dcb_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        dcb_pkg::CFG_MEAN:       mu   = longint'($signed(v));
        dcb_pkg::CFG_SIGMA:      sig  = v[dcb_pkg::SIG_W-1:0];
        dcb_pkg::CFG_LOW_ALPHA:  a_lo = v[dcb_pkg::ALPHA_W-1:0];
        dcb_pkg::CFG_LOW_POWER:  n_lo = v[dcb_pkg::POWER_W-1:0];
        dcb_pkg::CFG_HIGH_ALPHA: a_hi = v[dcb_pkg::ALPHA_W-1:0];
        dcb_pkg::CFG_HIGH_POWER: n_hi = v[dcb_pkg::POWER_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted sample: queue its density
    function void note_sample(logic signed [dcb_pkg::X_W-1:0] x);
      longint d;
      longint unsigned mag, um, res;
      bit neg;
      d = longint'(x) - mu;
      neg = d < 0;
      mag = neg ? -d : d;
      um = (mag << FRAC) / one_lsb(sig);
      if (neg && um > one_lsb(a_lo))
        res = tail_density(one_lsb(a_lo), one_lsb(n_lo), um - one_lsb(a_lo));
      else if (neg || um < one_lsb(a_hi))
        res = (um >= FAR_Q) ? 0 : exp2_neg((((um * um) >> 2) * HALF_L2E) >> 24);
      else
        res = tail_density(one_lsb(a_hi), one_lsb(n_hi), um - one_lsb(a_hi));
      density_q.push_back(res[dcb_pkg::OUT_W-1:0]);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_density(logic [dcb_pkg::OUT_W-1:0] got);
      logic [dcb_pkg::OUT_W-1:0] want;
      if (density_q.size() == 0) begin
        report($sformatf("unexpected density %0d", got));
        return;
      end
      want = density_q.pop_front();
      if (got !== want) report($sformatf("density %0d, expected %0d", got, want));
    endtask
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [dcb_pkg::CFG_ADDR_W-1:0]    cfg_addr_i = '0;
  logic [dcb_pkg::CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [dcb_pkg::X_W-1:0]    sample_x_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [dcb_pkg::OUT_W-1:0]         density_value_o;

  density_board board = new();
  bit  calm = 1'b0;
  int  quiet_cycles = 0;

  double_crystal_ball_eval dut (.*);

  always #4 clk_i = ~clk_i;

  // receiver stalls at random except in calm stretches
  always @(posedge clk_i)
    out_stall_i <= !calm && ($urandom_range(99) < 33);

  // monitors and watchdog
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) board.note_sample(sample_x_i);
    if (out_valid_o && !out_stall_i) board.check_density(density_value_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else if (rst_ni) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("double_crystal_ball_eval regression: fail");
      $finish;
    end
  end

  task automatic send_sample(logic signed [dcb_pkg::X_W-1:0] x);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain the pipe fully, then write one register
  task automatic write_reg(logic [dcb_pkg::CFG_ADDR_W-1:0] idx,
                           logic [dcb_pkg::CFG_DATA_W-1:0] v);
    in_valid_i <= 1'b0;
    while (board.density_q.size() != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, v);
  endtask

  task automatic set_shape(logic [31:0] m, logic [31:0] s, logic [31:0] al,
                           logic [31:0] nl, logic [31:0] ah, logic [31:0] nh);
    write_reg(dcb_pkg::CFG_MEAN, m);
    write_reg(dcb_pkg::CFG_SIGMA, s);
    write_reg(dcb_pkg::CFG_LOW_ALPHA, al);
    write_reg(dcb_pkg::CFG_LOW_POWER, nl);
    write_reg(dcb_pkg::CFG_HIGH_ALPHA, ah);
    write_reg(dcb_pkg::CFG_HIGH_POWER, nh);
  endtask

  // samples spread around the mean over many scales
  task automatic random_samples(int count);
    logic signed [31:0] off;
    for (int i = 0; i < count; i++) begin
      off = $signed($urandom) >>> $urandom_range(31, 8);
      if ($urandom_range(9) == 0) off = $urandom;
      send_sample(32'(board.mu) + off);
    end
  endtask

  initial begin
    logic signed [31:0] s2;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at reset settings
    s2 = 32'sd131072;
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(0);
    send_sample(1);
    send_sample(-1);
    send_sample(-s2);
    send_sample(-s2 - 1);
    send_sample(s2);
    send_sample(s2 - 1);
    send_sample(32'sh000f_ffff);
    send_sample(32'sh0010_0000);
    send_sample(-32'sh0010_0000);
    send_sample(32'sh0040_0000);
    send_sample(-32'sh0040_0000);
    random_samples(200);

    // zero registers act as one LSB; spare index ignored
    set_shape(0, 0, 0, 0, 0, 0);
    write_reg(CFG_SPARE, 32'hffff_ffff);
    send_sample(0);
    send_sample(1);
    send_sample(-1);
    send_sample(32'sh7fff_ffff);
    random_samples(150);

    // extremes: large alpha, maximal powers, wide sigma, mean at the ends
    set_shape(32'h8000_0000, 32'h7fff_ffff, 20'hfffff, 24'hffffff, 20'hfffff, 24'hffffff);
    random_samples(150);
    calm = 1'b1;
    set_shape(32'h7fff_ffff, 1, 1, 1, 1, 1);
    random_samples(200);
    calm = 1'b0;
    set_shape(32'hffff_0000, 32'h0000_8000, 20'h0_4000, 24'hff_ffff, 20'hf_ffff, 24'h00_0001);
    random_samples(200);

    // random mid-range shapes
    for (int p = 0; p < 5; p++) begin
      set_shape($urandom, $urandom_range(32'h0010_0000, 32'h0000_4000),
                $urandom_range(20'hf_ffff, 20'h0_2000), $urandom_range(24'h80_0000, 24'h0_4000),
                $urandom_range(20'hf_ffff, 20'h0_2000), $urandom_range(24'h80_0000, 24'h0_4000));
      random_samples(210);
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (board.density_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (board.errors == 0)
      $display("double_crystal_ball_eval regression: pass");
    else
      $display("double_crystal_ball_eval regression: fail");
    $finish;
  end

endmodule
